### rtl/hex_record_byte_extractor_defines.svh
// ----------------------------------------------------------------------------
// hex_record_byte_extractor_defines.svh
// Assertion macros shared by the hex record byte extractor checkers.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_BYTE_EXTRACTOR_DEFINES_SVH
`define HEX_RECORD_BYTE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HRBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrbe assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HRBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrbe assertion failed");

`endif

### rtl/hrbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_pkg
// Shared types, constants and the hex digit decode for the hex record
// byte extractor.
// ----------------------------------------------------------------------------
package hrbe_pkg;

    // Default width of the running byte index
    localparam int INDEX_BITS_DEFAULT = 20;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int BYTE_W  = 8;
    localparam int BIDX_W  = 20;
    localparam int ADDR_W  = 16;
    localparam int CCNT_W  = 6;
    localparam int ADIG_W  = 3;

    // Characters
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_F  = 8'h66;

    // Offsets from ASCII code to digit value
    localparam logic [CH_W-1:0] OFS_UPPER = 8'd55;
    localparam logic [CH_W-1:0] OFS_LOWER = 8'd87;
    localparam logic [CH_W-1:0] OFS_DIGIT = 8'd48;

    // Record layout: body digits occupy character counts 7 through 38
    localparam logic [CCNT_W-1:0] BODY_FIRST   = 6'd7;
    localparam logic [CCNT_W-1:0] BODY_LAST    = 6'd38;
    localparam logic [CCNT_W-1:0] CCNT_AFTER_ADDR = 6'd4;
    localparam logic [ADIG_W-1:0] ADDR_DIGITS  = 3'd4;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BIDX_W-1:0] byte_index;
        logic [ADDR_W-1:0] load_address;
    } t_result;

    // Result of one character, parser to output buffer
    typedef struct packed {
        logic    valid;
        t_result result;
    } t_emit;

    // ASCII hex digit to value; anything else decodes as zero
    function automatic logic [3:0] hex_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] v;
        v = '0;
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - OFS_UPPER;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - OFS_LOWER;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - OFS_DIGIT;
        end
        return v[3:0];
    endfunction

endpackage

### rtl/hrbe_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_parser
// Eight-state record parser. Takes one character per accepted transfer,
// updates its state at that edge and shows the byte it completes, if any,
// in the same cycle.
// ----------------------------------------------------------------------------
module hrbe_parser #(
    parameter int INDEX_BITS = hrbe_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [hrbe_pkg::CH_W-1:0]  i_ch,
    output hrbe_pkg::t_emit            o_emit
);

    typedef enum logic [2:0] {
        ST_WAIT  = 3'd0,
        ST_CNT1  = 3'd1,
        ST_CNT2  = 3'd2,
        ST_ADDR  = 3'd3,
        ST_FIRST = 3'd4,
        ST_SKIP  = 3'd5,
        ST_BODY  = 3'd6,
        ST_CNT0  = 3'd7
    } t_parse_state;

    t_parse_state                      r_state,      n_state;
    logic [hrbe_pkg::CCNT_W-1:0]       r_char_cnt,   n_char_cnt;
    logic [hrbe_pkg::ADIG_W-1:0]       r_addr_cnt,   n_addr_cnt;
    logic [hrbe_pkg::ADDR_W-1:0]       r_start_addr, n_start_addr;
    logic                              r_addr_seen,  n_addr_seen;
    logic [INDEX_BITS-1:0]             r_next_idx,   n_next_idx;
    logic                              r_second,     n_second;
    logic [3:0]                        r_high_nib,   n_high_nib;

    logic [3:0]                        nib;
    logic [31:0]                       idx_ext;

    assign nib     = hrbe_pkg::hex_value(i_ch);
    assign idx_ext = 32'(r_next_idx);

    // Next state and byte completion for the current character
    always_comb begin
        logic [hrbe_pkg::CCNT_W-1:0] cnt_inc;
        logic [hrbe_pkg::ADIG_W-1:0] adig_inc;
        logic [hrbe_pkg::ADDR_W-1:0] addr_sh;

        cnt_inc  = r_char_cnt + 1'b1;
        adig_inc = r_addr_cnt + 1'b1;
        addr_sh  = {r_start_addr[hrbe_pkg::ADDR_W-5:0], nib};

        n_state      = r_state;
        n_char_cnt   = r_char_cnt;
        n_addr_cnt   = r_addr_cnt;
        n_start_addr = r_start_addr;
        n_addr_seen  = r_addr_seen;
        n_next_idx   = r_next_idx;
        n_second     = r_second;
        n_high_nib   = r_high_nib;

        o_emit.valid                = 1'b0;
        o_emit.result.data_byte     = {r_high_nib, nib};
        o_emit.result.byte_index    = idx_ext[hrbe_pkg::BIDX_W-1:0];
        o_emit.result.load_address  = r_start_addr;

        case (r_state)
            ST_WAIT, ST_SKIP: begin
                if (i_ch == hrbe_pkg::CH_COLON) begin
                    n_state = ST_CNT1;
                end
            end
            ST_CNT1: begin
                if (i_ch == hrbe_pkg::CH_ONE) begin
                    n_state = ST_CNT2;
                end else if (i_ch == hrbe_pkg::CH_ZERO) begin
                    n_state = ST_CNT0;
                end
            end
            ST_CNT2: begin
                if (i_ch == hrbe_pkg::CH_ZERO) begin
                    if (!r_addr_seen) begin
                        n_state      = ST_ADDR;
                        n_start_addr = '0;
                        n_addr_cnt   = '0;
                    end else begin
                        n_state    = ST_BODY;
                        n_char_cnt = '0;
                        n_second   = 1'b0;
                    end
                end
            end
            ST_ADDR: begin
                n_addr_cnt   = adig_inc;
                n_start_addr = addr_sh;
                if (adig_inc >= hrbe_pkg::ADDR_DIGITS) begin
                    n_char_cnt  = hrbe_pkg::CCNT_AFTER_ADDR;
                    n_second    = 1'b0;
                    n_addr_seen = 1'b1;
                    n_state     = ST_FIRST;
                    n_next_idx  = INDEX_BITS'(nib);
                end
            end
            ST_FIRST, ST_BODY: begin
                n_char_cnt = cnt_inc;
                if (cnt_inc >= hrbe_pkg::BODY_FIRST) begin
                    n_high_nib = nib;
                    if (!r_second) begin
                        n_second = 1'b1;
                    end else begin
                        // second digit completes a byte
                        n_second     = 1'b0;
                        o_emit.valid = 1'b1;
                        n_next_idx   = r_next_idx + 1'b1;
                    end
                end
                if (cnt_inc >= hrbe_pkg::BODY_LAST) begin
                    n_state = ST_SKIP;
                end
                // a colon restarts the record, after counting as a digit
                if (i_ch == hrbe_pkg::CH_COLON) begin
                    n_state = ST_CNT1;
                end
            end
            ST_CNT0: begin
                if (i_ch == hrbe_pkg::CH_ONE) begin
                    n_state    = ST_BODY;
                    n_char_cnt = '0;
                    n_second   = 1'b0;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase

        if (!i_accept) begin
            o_emit.valid = 1'b0;
        end
    end

    // Parser state, updated on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WAIT;
            r_char_cnt   <= '0;
            r_addr_cnt   <= '0;
            r_start_addr <= '0;
            r_addr_seen  <= 1'b0;
            r_next_idx   <= '0;
            r_second     <= 1'b0;
            r_high_nib   <= '0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_char_cnt   <= n_char_cnt;
            r_addr_cnt   <= n_addr_cnt;
            r_start_addr <= n_start_addr;
            r_addr_seen  <= n_addr_seen;
            r_next_idx   <= n_next_idx;
            r_second     <= n_second;
            r_high_nib   <= n_high_nib;
        end
    end

endmodule

### rtl/hex_record_byte_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_byte_extractor
// Parses a simplified hex record text one character at a time and emits
// each data byte with its running index and the captured load address.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------
//   char    | in  | i_valid / o_stall  | i_ch
//   byte    | out | o_valid / i_stall  | o_data_byte, o_byte_index,
//           |     |                    | o_load_address
//
// One character per cycle while o_stall is low; a completed byte enters the
// result register, or the skid entry while the output is stalled. The parser
// state updates on each accepted character. A result register plus one skid
// entry decouple the two sides: o_stall rises only when both hold a byte. Reset
// is synchronous, active low, and clears the parser and both valid flags.
// ----------------------------------------------------------------------------
module hex_record_byte_extractor #(
    parameter int INDEX_BITS = hrbe_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [hrbe_pkg::CH_W-1:0]    i_ch,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hrbe_pkg::BYTE_W-1:0]  o_data_byte,
    output logic [hrbe_pkg::BIDX_W-1:0]  o_byte_index,
    output logic [hrbe_pkg::ADDR_W-1:0]  o_load_address
);

    logic              in_xfer;
    hrbe_pkg::t_emit   emit;

    logic              r_out_valid,  n_out_valid;
    hrbe_pkg::t_result r_out,        n_out;
    logic              r_skid_valid, n_skid_valid;
    hrbe_pkg::t_result r_skid,       n_skid;

    assign o_stall = r_skid_valid;
    assign in_xfer = i_valid && !r_skid_valid;

    hrbe_parser #(
        .INDEX_BITS (INDEX_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_ch     (i_ch),
        .o_emit   (emit)
    );

    // Output register and skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_stall) begin
            // output slot frees up at this edge
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = emit.result;
                n_out_valid = emit.valid;
            end
        end else if (emit.valid) begin
            n_skid       = emit.result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid        = r_out_valid;
    assign o_data_byte    = r_out.data_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_load_address = r_out.load_address;

endmodule

### rtl/hrbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbe_checker
// Port-level checks on the hex record byte extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_record_byte_extractor_defines.svh"

module hrbe_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [hrbe_pkg::BYTE_W-1:0]  o_data_byte,
    input  logic [hrbe_pkg::BIDX_W-1:0]  o_byte_index,
    input  logic [hrbe_pkg::ADDR_W-1:0]  o_load_address
);

    // A held byte stays offered until taken
    `HRBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A held byte keeps its value
    `HRBE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_data_byte) && $stable(o_byte_index) && $stable(o_load_address))

    // The skid entry is only occupied behind a full output register
    `HRBE_ASSERT_IMPL(a_stall_needs_out, i_clk, i_rst_n, o_stall, o_valid)

    // The skid entry only fills while the output is stalled
    `HRBE_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, $rose(o_stall), $past(o_valid && i_stall))

endmodule

bind hex_record_byte_extractor hrbe_checker u_hrbe_checker (.*);
